// ===== rtl/ava_pkg.sv =====
// Shared types and constants for the audio voice allocator.
package ava_pkg;

  // Number of mixer channels, one storage cell per channel.
  localparam int unsigned CHANNEL_COUNT = 8;
  localparam int unsigned IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  // Field widths fixed by the interface.
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned CHAN_W = 3;

  // Channels that have a busy bit in the request mask.
  localparam int unsigned MASKED_COUNT = (CHANNEL_COUNT < MASK_W) ? CHANNEL_COUNT : MASK_W;

  // Contents of one channel cell.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] start_time;
  } voice_t;

  // Control for one cell: rotate the ring or load a new voice.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

endpackage

// ===== rtl/audio_voice_allocator.sv =====
// Top level of the audio voice allocator: channel ring and scan sequencer.
//
// Usage: drive request_priority_i, now_time_i and busy_mask_i and raise
// start. The item is taken at a rising edge where start is high and
// busy is low. Each item gives exactly one result, shown on
// chosen_channel_o and stole_voice_o for one cycle with done_o high.
// If a channel is idle, the lowest-indexed idle one is chosen and the item
// goes straight to write-back, where the result is registered. If every
// channel is busy, the stored voices rotate once round the ring of
// CHANNEL_COUNT cells, one cell a cycle, past a single comparator at the head,
// which keeps the lowest priority and then the oldest start time; write-back
// follows the last channel. busy is high from acceptance until the chosen
// cell has been written; the rotation sets the worst-case throughput.
// Reset clears every stored priority and start time to zero and leaves the
// block idle. The receiver cannot stall: each result is held for one cycle
// only, and a new item may be accepted in the cycle that shows a result.
module audio_voice_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ava_pkg::PRIO_W-1:0] request_priority_i,
  input  logic [ava_pkg::TIME_W-1:0] now_time_i,
  input  logic [ava_pkg::MASK_W-1:0] busy_mask_i,
  output logic                       done_o,
  output logic [ava_pkg::CHAN_W-1:0] chosen_channel_o,
  output logic                       stole_voice_o
);

  localparam int unsigned N = ava_pkg::CHANNEL_COUNT;

  ava_pkg::state_e state_q, state_d;
  logic [ava_pkg::IDX_W-1:0] cnt_q, cnt_d;
  logic [ava_pkg::IDX_W-1:0] pick_q, pick_d;
  logic                      have_q, have_d;
  logic                      stole_q, stole_d;
  ava_pkg::voice_t           req_q, req_d;
  ava_pkg::voice_t           best_q, best_d;
  logic                      done_q, done_d;
  logic [ava_pkg::CHAN_W-1:0] chan_q, chan_d;
  logic                      stole_out_q, stole_out_d;

  ava_pkg::voice_t    cell_voice [N];
  ava_pkg::cell_ctrl_t cell_ctrl [N];

  logic                      accept;
  logic                      idle_found;
  logic [ava_pkg::IDX_W-1:0] idle_idx;

  assign accept = start && !busy;
  assign busy   = (state_q != ava_pkg::ST_IDLE);

  // Ring of channel cells; each cell takes the voice of the next one up.
  for (genvar g = 0; g < N; g++) begin : g_cell
    ava_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[g]),
      .ring_i  (cell_voice[(g + 1) % N]),
      .load_i  (req_q),
      .voice_o (cell_voice[g])
    );
  end

  // Cell controls: rotate during the scan, load the chosen cell at write-back.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_ctrl[i].shift = (state_q == ava_pkg::ST_SCAN);
      cell_ctrl[i].load  = (state_q == ava_pkg::ST_WRITE) &&
                           (pick_q == ava_pkg::IDX_W'(i));
    end
  end

  // Lowest-indexed idle channel among those that have a mask bit.
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = ava_pkg::MASKED_COUNT - 1; i >= 0; i--) begin
      if (!busy_mask_i[i]) begin
        idle_found = 1'b1;
        idle_idx   = ava_pkg::IDX_W'(i);
      end
    end
  end

  // Sequencer: next state, scan comparison and result.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pick_d      = pick_q;
    have_d      = have_q;
    stole_d     = stole_q;
    req_d       = req_q;
    best_d      = best_q;
    done_d      = 1'b0;
    chan_d      = chan_q;
    stole_out_d = stole_out_q;
    unique case (state_q)
      ava_pkg::ST_IDLE: begin
        if (accept) begin
          req_d.prio       = request_priority_i;
          req_d.start_time = now_time_i;
          cnt_d            = '0;
          have_d           = 1'b0;
          pick_d           = idle_idx;
          stole_d          = !idle_found;
          state_d          = idle_found ? ava_pkg::ST_WRITE : ava_pkg::ST_SCAN;
        end
      end
      ava_pkg::ST_SCAN: begin
        // The head cell shows channel cnt_q; strict compare keeps the lowest index.
        if (!have_q || ({cell_voice[0].prio, cell_voice[0].start_time} <
                        {best_q.prio, best_q.start_time})) begin
          best_d = cell_voice[0];
          pick_d = cnt_q;
          have_d = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ava_pkg::IDX_W'(N - 1)) begin
          state_d = ava_pkg::ST_WRITE;
        end
      end
      ava_pkg::ST_WRITE: begin
        done_d      = 1'b1;
        chan_d      = ava_pkg::CHAN_W'(pick_q);
        stole_out_d = stole_q;
        state_d     = ava_pkg::ST_IDLE;
      end
      default: begin
        state_d = ava_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ava_pkg::ST_IDLE;
      cnt_q   <= '0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      have_q  <= have_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pick_q      <= pick_d;
    stole_q     <= stole_d;
    req_q       <= req_d;
    best_q      <= best_d;
    chan_q      <= chan_d;
    stole_out_q <= stole_out_d;
  end

  assign done_o           = done_q;
  assign chosen_channel_o = chan_q;
  assign stole_voice_o    = stole_out_q;

  // A result strobe follows a write-back cycle and nothing else.
  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ava_pkg::ST_WRITE))
    else $error("result strobe without write-back");

  // A scan always ends in write-back after the last channel.
  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ava_pkg::ST_SCAN && cnt_q == ava_pkg::IDX_W'(N - 1))
      |=> state_q == ava_pkg::ST_WRITE)
    else $error("scan did not end in write-back");

  // Write-back after a scan always has a candidate.
  a_write_has_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ava_pkg::ST_WRITE && stole_q) |-> have_q)
    else $error("steal without a candidate");

  // An accepted item whose mask shows an idle channel goes straight to write-back.
  a_idle_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && idle_found) |=> (state_q == ava_pkg::ST_WRITE && !stole_q))
    else $error("idle channel not taken directly");

endmodule

// ===== rtl/ava_cell.sv =====
// One channel cell: stores a voice and passes it to its neighbour in the ring.
module ava_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ava_pkg::cell_ctrl_t ctrl_i,
  input  ava_pkg::voice_t     ring_i,
  input  ava_pkg::voice_t     load_i,
  output ava_pkg::voice_t     voice_o
);

  ava_pkg::voice_t voice_q, voice_d;

  // A load takes the new voice; a shift takes the neighbour's voice.
  always_comb begin
    voice_d = voice_q;
    if (ctrl_i.load) begin
      voice_d = load_i;
    end else if (ctrl_i.shift) begin
      voice_d = ring_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else begin
      voice_q <= voice_d;
    end
  end

  assign voice_o = voice_q;

endmodule
